>>> hw/rtl/merge_sort_block_defines.svh
// Shared assertion macros for the merge sort block checker.
`ifndef MERGE_SORT_BLOCK_DEFINES_SVH
`define MERGE_SORT_BLOCK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/msb_pkg.sv
`timescale 1ns / 1ps

package msb_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CHECK,
        S_PRIME,
        S_MERGE,
        S_EMIT_PRIME,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_PRIME,
        OP_MERGE,
        OP_EMIT_PRIME,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic sort_done;  // current run width already covers the block
        logic last_pass;  // the pass now running is the final one
        logic pass_end;   // the merge step in this cycle closes the pass
        logic emit_last;  // the emit step in this cycle sends the final element
    } t_dp_status;

endpackage

>>> hw/rtl/merge_sort_block.sv
`timescale 1ns / 1ps

// Channel   Transfer when         Signals
// -------   -------------------   ------------------------------------------
// input     start && !busy        i_value, i_last
// result    o_strobe              o_sorted_value, o_end_of_block, o_overflow
//
// After the last element of a block, the n elements held are sorted in
// merge passes: one shared merge unit moves one element per cycle through
// the two-read-port buffers, with a prime step before each pass.
// Reset is synchronous and active low; busy stays high from the last
// element until the final result, and results cannot be held off.
module merge_sort_block
    import msb_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_strobe,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_end_of_block,
    output logic                     o_overflow
);

    t_dp_op     op;
    t_dp_status status;

    msb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_last),
        .i_status (status),
        .o_busy   (busy),
        .o_op     (op)
    );

    msb_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_value        (i_value),
        .o_status       (status),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_end_of_block (o_end_of_block),
        .o_overflow     (o_overflow)
    );

endmodule

>>> hw/rtl/msb_ram.sv
`timescale 1ns / 1ps

module msb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> hw/rtl/msb_ctrl.sv
`timescale 1ns / 1ps

module msb_ctrl
    import msb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_last,
    input  t_dp_status i_status,
    output logic       o_busy,
    output t_dp_op     o_op
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        o_busy  = 1'b1;
        unique case (r_state)
            S_LOAD: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_op = OP_LOAD;
                    if (i_last) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_state = i_status.sort_done ? S_EMIT_PRIME : S_PRIME;
            end
            S_PRIME: begin
                o_op    = OP_PRIME;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                o_op = OP_MERGE;
                if (i_status.pass_end) begin
                    n_state = i_status.last_pass ? S_EMIT_PRIME : S_PRIME;
                end
            end
            S_EMIT_PRIME: begin
                o_op    = OP_EMIT_PRIME;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_op = OP_EMIT;
                if (i_status.emit_last) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

>>> hw/rtl/msb_datapath.sv
`timescale 1ns / 1ps

module msb_datapath
    import msb_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_op                   i_op,
    input  logic signed [DATA_W-1:0] i_value,
    output t_dp_status               o_status,
    output logic                     o_strobe,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_end_of_block,
    output logic                     o_overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 2;

    // Control state.
    logic [CW-1:0] r_fill, n_fill;
    logic          r_ovf, n_ovf;
    logic [CW:0]   r_w, n_w;
    logic          r_par, n_par;
    logic          r_strobe, n_strobe;
    logic          r_end, n_end;

    // Merge cursors and result payload.
    logic [CW-1:0]            r_a, n_a;
    logic [CW-1:0]            r_mid, n_mid;
    logic [CW-1:0]            r_b, n_b;
    logic [CW-1:0]            r_hi, n_hi;
    logic [CW-1:0]            r_k, n_k;
    logic signed [DATA_W-1:0] r_out_value, n_out_value;
    logic                     r_out_ovf, n_out_ovf;

    logic [DATA_W-1:0]        rd0_a, rd0_b, rd1_a, rd1_b;
    logic signed [DATA_W-1:0] head_a, head_b, merge_data;
    logic                     take_a;

    logic [SW-1:0] n_ext, w_ext, w2_ext;
    logic [CW-1:0] seg_base, seg_mid, seg_hi, k_inc;
    logic [SW-1:0] seg_mid_sum, seg_hi_sum;
    logic          seg_end;
    logic          room;

    logic [CW-1:0]     raddr_a, raddr_b;
    logic              we0, we1;
    logic [AW-1:0]     waddr0;
    logic [DATA_W-1:0] wdata0;

    // Buffer 0 holds the loaded block; the passes alternate between the two.
    msb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram0 (
        .i_clk     (i_clk),
        .i_we      (we0),
        .i_waddr   (waddr0),
        .i_wdata   (wdata0),
        .i_raddr_a (raddr_a[AW-1:0]),
        .i_raddr_b (raddr_b[AW-1:0]),
        .o_rdata_a (rd0_a),
        .o_rdata_b (rd0_b)
    );

    msb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram1 (
        .i_clk     (i_clk),
        .i_we      (we1),
        .i_waddr   (r_k[AW-1:0]),
        .i_wdata   (merge_data),
        .i_raddr_a (raddr_a[AW-1:0]),
        .i_raddr_b (raddr_b[AW-1:0]),
        .o_rdata_a (rd1_a),
        .o_rdata_b (rd1_b)
    );

    assign head_a     = r_par ? rd1_a : rd0_a;
    assign head_b     = r_par ? rd1_b : rd0_b;
    assign take_a     = (r_a < r_mid) && ((r_b >= r_hi) || (head_a <= head_b));
    assign merge_data = take_a ? head_a : head_b;

    assign n_ext  = SW'(r_fill);
    assign w_ext  = SW'(r_w);
    assign w2_ext = w_ext << 1;

    // Bounds of the next pair of runs; a pass starts its first pair at zero.
    assign seg_base    = (i_op == OP_PRIME) ? '0 : r_hi;
    assign seg_mid_sum = SW'(seg_base) + w_ext;
    assign seg_hi_sum  = SW'(seg_base) + w2_ext;
    assign seg_mid     = (seg_mid_sum > n_ext) ? r_fill : seg_mid_sum[CW-1:0];
    assign seg_hi      = (seg_hi_sum > n_ext) ? r_fill : seg_hi_sum[CW-1:0];

    assign k_inc   = r_k + 1'b1;
    assign seg_end = (k_inc == r_hi);
    assign room    = (r_fill < CW'(MAX_ITEMS));

    assign o_status.sort_done = (w_ext >= n_ext);
    assign o_status.last_pass = (w2_ext >= n_ext);
    assign o_status.pass_end  = seg_end && (r_hi == r_fill);
    assign o_status.emit_last = (k_inc == r_fill);

    assign we0    = ((i_op == OP_LOAD) && room) || ((i_op == OP_MERGE) && r_par);
    assign we1    = (i_op == OP_MERGE) && !r_par;
    assign waddr0 = (i_op == OP_LOAD) ? r_fill[AW-1:0] : r_k[AW-1:0];
    assign wdata0 = (i_op == OP_LOAD) ? i_value : merge_data;

    always_comb begin
        n_fill      = r_fill;
        n_ovf       = r_ovf;
        n_w         = r_w;
        n_par       = r_par;
        n_a         = r_a;
        n_mid       = r_mid;
        n_b         = r_b;
        n_hi        = r_hi;
        n_k         = r_k;
        n_strobe    = 1'b0;
        n_end       = 1'b0;
        n_out_value = head_a;
        n_out_ovf   = r_ovf;
        raddr_a     = '0;
        raddr_b     = '0;
        unique case (i_op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                if (room) begin
                    n_fill = r_fill + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
            end
            OP_PRIME: begin
                n_a   = '0;
                n_mid = seg_mid;
                n_b   = seg_mid;
                n_hi  = seg_hi;
                n_k   = '0;
            end
            OP_MERGE: begin
                n_k = k_inc;
                if (seg_end) begin
                    n_a   = r_hi;
                    n_mid = seg_mid;
                    n_b   = seg_mid;
                    n_hi  = seg_hi;
                end else if (take_a) begin
                    n_a = r_a + 1'b1;
                end else begin
                    n_b = r_b + 1'b1;
                end
                if (o_status.pass_end) begin
                    n_w   = r_w << 1;
                    n_par = ~r_par;
                end
            end
            OP_EMIT_PRIME: begin
                n_k = '0;
            end
            OP_EMIT: begin
                n_k      = k_inc;
                n_strobe = 1'b1;
                n_end    = o_status.emit_last;
                if (o_status.emit_last) begin
                    n_fill = '0;
                    n_ovf  = 1'b0;
                    n_w    = (CW + 1)'(1);
                    n_par  = 1'b0;
                end
            end
            default: begin
            end
        endcase
        // The buffers are addressed with the next cursors so that the heads
        // are ready in the cycle the cursors take effect.
        if (i_op == OP_EMIT_PRIME || i_op == OP_EMIT) begin
            raddr_a = n_k;
        end else if (i_op == OP_PRIME || i_op == OP_MERGE) begin
            raddr_a = n_a;
            raddr_b = n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_ovf    <= 1'b0;
            r_w      <= (CW + 1)'(1);
            r_par    <= 1'b0;
            r_strobe <= 1'b0;
            r_end    <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_ovf    <= n_ovf;
            r_w      <= n_w;
            r_par    <= n_par;
            r_strobe <= n_strobe;
            r_end    <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_mid       <= n_mid;
        r_b         <= n_b;
        r_hi        <= n_hi;
        r_k         <= n_k;
        r_out_value <= n_out_value;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_strobe       = r_strobe;
    assign o_sorted_value = r_out_value;
    assign o_end_of_block = r_end;
    assign o_overflow     = r_out_ovf;

endmodule

>>> hw/rtl/msb_checker.sv
`timescale 1ns / 1ps
`include "merge_sort_block_defines.svh"

module msb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last,
    input logic o_strobe,
    input logic o_end_of_block
);

    // A result only follows a cycle in which the block was sorting.
    `MSB_ASSERT_NOW(a_result_while_busy, i_clk, i_rst_n, o_strobe, $past(busy), "result without sort")

    // The final element of a block starts the sort at once.
    `MSB_ASSERT_NEXT(a_last_starts_sort, i_clk, i_rst_n, start && !busy && i_last, busy, "no sort after last")

    `MSB_ASSERT_NOW(a_end_has_strobe, i_clk, i_rst_n, o_end_of_block, o_strobe, "end flag without result")

    // Results of one block come in consecutive cycles up to the end flag.
    `MSB_ASSERT_NEXT(a_results_contiguous, i_clk, i_rst_n, o_strobe && !o_end_of_block, o_strobe, "gap in results")

    `MSB_ASSERT_NEXT(a_end_stops_results, i_clk, i_rst_n, o_end_of_block, !o_strobe, "result after end flag")

endmodule

bind merge_sort_block msb_checker u_checker (.*);

>>> tb/merge_sort_block_checker.sv
`timescale 1ns / 1ps

module merge_sort_block_checker
    import msb_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last,
    input  logic                     i_strobe,
    input  logic signed [DATA_W-1:0] i_sorted_value,
    input  logic                     i_end_of_block,
    input  logic                     i_overflow,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     end_of_block;
        logic                     overflow;
    } t_sorted_entry;

    t_sorted_entry            pending_sorted_q[$];
    logic signed [DATA_W-1:0] held_vals [MAX_ITEMS];
    int                       held_count     = 0;
    logic                     dropped_seen   = 1'b0;
    int                       mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // Stores one element of the block; on the final element the held values
    // are sorted and the whole block is queued as expected results.
    function automatic void absorb_element(input logic signed [DATA_W-1:0] value,
                                           input logic last_flag);
        logic signed [DATA_W-1:0] key;
        int                       j;
        t_sorted_entry            entry;
        if (held_count < MAX_ITEMS) begin
            held_vals[held_count] = value;
            held_count++;
        end else begin
            dropped_seen = 1'b1;
        end
        if (last_flag) begin
            // Insertion sort with a strict compare keeps equal keys in order.
            for (int i = 1; i < held_count; i++) begin
                key = held_vals[i];
                j   = i - 1;
                while (j >= 0 && held_vals[j] > key) begin
                    held_vals[j + 1] = held_vals[j];
                    j--;
                end
                held_vals[j + 1] = key;
            end
            for (int i = 0; i < held_count; i++) begin
                entry.value        = held_vals[i];
                entry.end_of_block = (i == held_count - 1);
                entry.overflow     = dropped_seen;
                pending_sorted_q.push_back(entry);
            end
            held_count   = 0;
            dropped_seen = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_sorted_entry want;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (pending_sorted_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result: value %0d eob %0b ovf %0b",
                                 i_sorted_value, i_end_of_block, i_overflow);
                    end
                end else begin
                    want = pending_sorted_q.pop_front();
                    if (want.value !== i_sorted_value ||
                        want.end_of_block !== i_end_of_block ||
                        want.overflow !== i_overflow) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     $signed(want.value), want.end_of_block,
                                     want.overflow, i_sorted_value, i_end_of_block,
                                     i_overflow);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                absorb_element(i_value, i_last);
            end
        end
        o_pending <= pending_sorted_q.size();
    end

endmodule

>>> tb/tb_merge_sort_block.sv
`timescale 1ns / 1ps

module tb_merge_sort_block;
    import msb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] i_value;
    logic                     i_last;
    logic                     o_strobe;
    logic signed [DATA_W-1:0] o_sorted_value;
    logic                     o_end_of_block;
    logic                     o_overflow;
    int                       fail_count;
    int                       pending;
    int                       idle_pct;
    int                       cycle_count;

    logic signed [DATA_W-1:0] directed_vals [24];
    int                       directed_sizes [7];

    merge_sort_block uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_end_of_block (o_end_of_block),
        .o_overflow     (o_overflow)
    );

    merge_sort_block_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_value        (i_value),
        .i_last         (i_last),
        .i_strobe       (o_strobe),
        .i_sorted_value (o_sorted_value),
        .i_end_of_block (o_end_of_block),
        .i_overflow     (o_overflow),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_merge_sort_block failed");
            $finish;
        end
    end

    // Extremes and a small pool of nearby values, so that ties are common.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5: return $signed($urandom_range(6)) - 32'sd3;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_element(input logic signed [DATA_W-1:0] value,
                                input logic last_flag);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= value;
        i_last  <= last_flag;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_block(input int size);
        for (int i = 0; i < size; i++) begin
            send_element(pick_value(), i == size - 1);
        end
    endtask

    // The count from the checker is registered, so it lags the queue.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int k;
        int phase_items;
        int size;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_value     = '0;
        i_last      = 1'b0;
        cycle_count = 0;
        idle_pct    = 23;
        directed_sizes = '{1, 1, 2, 3, 4, 8, 5};
        directed_vals  = '{
            32'sh80000000,
            32'sh7fffffff,
            32'sh7fffffff, 32'sh80000000,
            32'sd0, -32'sd1, 32'sd1,
            32'sd5, -32'sd5, 32'sd5, 32'sd5,
            32'sh7fffffff, 32'sd1000, 32'sd1, 32'sd0, -32'sd1, -32'sd1000,
            32'sh80000001, 32'sh80000000,
            32'sh80000000, 32'sh80000000, 32'sd0, 32'sh7fffffff, 32'sh7fffffff
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        k = 0;
        foreach (directed_sizes[b]) begin
            for (int i = 0; i < directed_sizes[b]; i++) begin
                send_element(directed_vals[k], i == directed_sizes[b] - 1);
                k++;
            end
        end
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 23 : (phase == 1) ? 74 : 0;
            // One full block and one block that runs past capacity, the
            // final element of the latter being dropped as well.
            if (phase == 0) begin
                send_block(MAX_ITEMS_DEF);
            end else if (phase == 1) begin
                send_block(MAX_ITEMS_DEF + 1 + $urandom_range(3));
            end
            phase_items = 0;
            while (phase_items < 3) begin
                size = $urandom_range(1, 8);
                send_block(size);
                phase_items += size;
            end
            wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_merge_sort_block passed");
        end else begin
            $display("tb_merge_sort_block failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/msb_pkg.sv
hw/rtl/msb_ram.sv
hw/rtl/msb_ctrl.sv
hw/rtl/msb_datapath.sv
hw/rtl/merge_sort_block.sv
hw/rtl/msb_checker.sv
tb/merge_sort_block_checker.sv
tb/tb_merge_sort_block.sv
